FILE: hw/rtl/jns_pkg.sv
// Package for the JSON number scanner: phase codes, state and result types, helpers.
package jns_pkg;

  // Number of decimal digits kept in the mantissa
  localparam int unsigned MANTISSA_DIGITS = 18;

  localparam int unsigned MantW = 60;
  localparam int unsigned ExpW  = 16;

  // Phase codes of the scanner
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_MINUS = 4'd1;
  localparam logic [3:0] PH_INT   = 4'd2;
  localparam logic [3:0] PH_ZERO  = 4'd3;
  localparam logic [3:0] PH_POINT = 4'd4;
  localparam logic [3:0] PH_FRAC  = 4'd5;
  localparam logic [3:0] PH_E     = 4'd6;
  localparam logic [3:0] PH_ESIGN = 4'd7;
  localparam logic [3:0] PH_EXP   = 4'd8;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;

  // Largest mantissa: 10^digits - 1, worked out at elaboration
  function automatic logic [63:0] calc_mant_max();
    logic [63:0] p;
    p = 64'd1;
    for (int k = 0; k < int'(MANTISSA_DIGITS) && k < 19; k++) begin
      p = p * 64'd10;
    end
    return p - 64'd1;
  endfunction

  localparam logic [63:0] MANT_MAX = calc_mant_max();

  // Largest accumulator that still takes digit d: (max - d) / 10
  function automatic logic [MantW-1:0] mant_limit(logic [3:0] d);
    logic [MantW-1:0] lim;
    case (d)
      4'd0:    lim = MantW'((MANT_MAX - 64'd0) / 64'd10);
      4'd1:    lim = MantW'((MANT_MAX - 64'd1) / 64'd10);
      4'd2:    lim = MantW'((MANT_MAX - 64'd2) / 64'd10);
      4'd3:    lim = MantW'((MANT_MAX - 64'd3) / 64'd10);
      4'd4:    lim = MantW'((MANT_MAX - 64'd4) / 64'd10);
      4'd5:    lim = MantW'((MANT_MAX - 64'd5) / 64'd10);
      4'd6:    lim = MantW'((MANT_MAX - 64'd6) / 64'd10);
      4'd7:    lim = MantW'((MANT_MAX - 64'd7) / 64'd10);
      4'd8:    lim = MantW'((MANT_MAX - 64'd8) / 64'd10);
      4'd9:    lim = MantW'((MANT_MAX - 64'd9) / 64'd10);
      default: lim = '0;
    endcase
    return lim;
  endfunction

  // Clamp an 18-bit signed value to 16 bits
  function automatic logic signed [ExpW-1:0] sat16(logic signed [17:0] v);
    logic signed [ExpW-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[ExpW-1:0];
    end
    return r;
  endfunction

  // Scanner state
  typedef struct packed {
    logic [3:0]              phase;
    logic [MantW-1:0]        mantissa;
    logic signed [ExpW-1:0]  exponent;
    logic                    negative;
    logic                    inexact;
    logic [15:0]             exp_digits;
    logic                    exp_neg;
  } jns_state_t;

  // One result transaction
  typedef struct packed {
    logic                    status;
    logic                    negative;
    logic [MantW-1:0]        mantissa;
    logic signed [ExpW-1:0]  exponent;
    logic                    inexact;
    logic [7:0]              stop_char;
    logic                    stop_is_end;
  } jns_result_t;

endpackage

FILE: hw/rtl/jns_in_if.sv
// Input channel of the JSON number scanner: one text byte per transaction.
interface jns_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, ch, end_of_input, input ready);
  modport sink   (input valid, ch, end_of_input, output ready);
endinterface

FILE: hw/rtl/jns_out_if.sv
// Output channel of the JSON number scanner: one scanned number or error per transaction.
interface jns_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic               negative;
  logic [59:0]        mantissa;
  logic signed [15:0] exponent;
  logic               inexact;
  logic [7:0]         stop_char;
  logic               stop_is_end;

  modport source (output valid, status, negative, mantissa, exponent, inexact,
                  stop_char, stop_is_end, input ready);
  modport sink   (input valid, status, negative, mantissa, exponent, inexact,
                  stop_char, stop_is_end, output ready);
endinterface

FILE: hw/rtl/json_number_scanner_unit.sv
// JSON number scanner: takes number text a byte at a time, returns the scanned number.
//
// Usage:
//   in_i  : one transaction per text byte (ch, end_of_input). end_of_input acts as a
//           terminator and its ch is ignored.
//   out_o : one transaction per number, or per syntax error: sign, decimal mantissa,
//           saturated exponent, inexact flag and the stop byte. The stop byte is not
//           part of the number and is not consumed; send it again as the first byte
//           of whatever follows if it matters.
// Throughput: one byte per cycle unless out_o stalls, set by the combinational digit
//   accumulate (mantissa times ten plus digit and limit compare) in jns_step.
// Result path: the stop byte goes through the input register, then the result register,
//   before its result shows as valid on out_o.
// Stall: while a result waits on out_o, at most one more byte is taken into the
//   input register; further bytes wait until the result is taken.
// Reset: rst_ni low clears the scanner to idle and drops all pending transactions.
module json_number_scanner_unit (
  input logic    clk_i,
  input logic    rst_ni,
  jns_in_if.sink   in_i,
  jns_out_if.source out_o
);
  import jns_pkg::*;

  logic        in_valid_q;
  logic [7:0]  ch_q;
  logic        eoi_q;
  jns_state_t  st_q, st_d;
  logic        emit;
  jns_result_t res, res_q;
  logic        out_valid_q;
  logic        fire;

  // Input byte is processed once the result register is free
  assign fire       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q  <= in_i.ch;
      eoi_q <= in_i.end_of_input;
    end
  end

  jns_step u_step (
    .st_i   (st_q),
    .ch_i   (ch_q),
    .eoi_i  (eoi_q),
    .st_o   (st_d),
    .emit_o (emit),
    .res_o  (res)
  );

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, mantissa: '0, exponent: '0, negative: 1'b0,
                inexact: 1'b0, exp_digits: '0, exp_neg: 1'b0};
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = res_q.status;
  assign out_o.negative    = res_q.negative;
  assign out_o.mantissa    = res_q.mantissa;
  assign out_o.exponent    = res_q.exponent;
  assign out_o.inexact     = res_q.inexact;
  assign out_o.stop_char   = res_q.stop_char;
  assign out_o.stop_is_end = res_q.stop_is_end;

endmodule

FILE: hw/rtl/jns_step.sv
// Next-state and result logic of the scanner for one byte.
module jns_step (
  input  jns_pkg::jns_state_t  st_i,
  input  logic [7:0]           ch_i,
  input  logic                 eoi_i,
  output jns_pkg::jns_state_t  st_o,
  output logic                 emit_o,
  output jns_pkg::jns_result_t res_o
);
  import jns_pkg::*;

  logic                   dig, is_dot, is_e, is_minus, is_plus;
  logic [3:0]             d;
  logic                   frac_mode, fits;
  logic [63:0]            mant_x10;
  logic [MantW-1:0]       mant_add;
  logic signed [ExpW-1:0] exp_add;
  logic                   inexact_add;
  logic [19:0]            edv_x10;
  logic [15:0]            edv_add;
  logic signed [17:0]     exp_sum;
  logic                   err, do_emit, do_digit;
  jns_state_t             clr;

  // Character classes
  assign dig      = !eoi_i && (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign d        = ch_i[3:0];
  assign is_dot   = !eoi_i && (ch_i == CH_POINT);
  assign is_e     = !eoi_i && ((ch_i == CH_LOW_E) || (ch_i == CH_UP_E));
  assign is_minus = !eoi_i && (ch_i == CH_MINUS);
  assign is_plus  = !eoi_i && (ch_i == CH_PLUS);

  // Mantissa digit accumulate
  assign frac_mode = (st_i.phase == PH_POINT) || (st_i.phase == PH_FRAC);
  assign fits      = st_i.mantissa <= mant_limit(dig ? d : 4'd0);
  assign mant_x10  = {st_i.mantissa, 3'b000} + {3'b000, st_i.mantissa, 1'b0} + {60'd0, d};
  assign mant_add  = fits ? mant_x10[MantW-1:0] : st_i.mantissa;
  assign inexact_add = st_i.inexact | (!fits && (d != 4'd0));

  always_comb begin
    exp_add = st_i.exponent;
    if (fits && frac_mode) begin
      exp_add = sat16(18'(st_i.exponent) - 18'sd1);
    end else if (!fits && !frac_mode) begin
      exp_add = sat16(18'(st_i.exponent) + 18'sd1);
    end
  end

  // Exponent digit accumulate, clamped at 65535
  assign edv_x10 = {st_i.exp_digits, 3'b000} + {3'b000, st_i.exp_digits, 1'b0} + {16'd0, d};
  assign edv_add = (edv_x10 > 20'd65535) ? 16'hffff : edv_x10[15:0];

  // Final exponent
  assign exp_sum = st_i.exp_neg ? 18'(st_i.exponent) - $signed({2'b00, st_i.exp_digits})
                                : 18'(st_i.exponent) + $signed({2'b00, st_i.exp_digits});

  assign clr = '{phase: PH_IDLE, mantissa: '0, exponent: '0, negative: 1'b0,
                 inexact: 1'b0, exp_digits: '0, exp_neg: 1'b0};

  // Phase decoder
  always_comb begin
    st_o     = st_i;
    do_emit  = 1'b0;
    err      = 1'b0;
    do_digit = 1'b0;
    unique case (st_i.phase)
      PH_IDLE, PH_MINUS: begin
        if (st_i.phase == PH_IDLE && is_minus) begin
          st_o.negative = 1'b1;
          st_o.phase    = PH_MINUS;
        end else if (!dig) begin
          do_emit = 1'b1;
          err     = 1'b1;
        end else if (d == 4'd0) begin
          st_o.phase = PH_ZERO;
        end else begin
          do_digit   = 1'b1;
          st_o.phase = PH_INT;
        end
      end
      PH_INT, PH_ZERO: begin
        if (st_i.phase == PH_INT && dig) begin
          do_digit = 1'b1;
        end else if (is_dot) begin
          st_o.phase = PH_POINT;
        end else if (is_e) begin
          st_o.phase = PH_E;
        end else begin
          do_emit = 1'b1;
        end
      end
      PH_POINT: begin
        if (!dig) begin
          do_emit = 1'b1;
          err     = 1'b1;
        end else begin
          do_digit   = 1'b1;
          st_o.phase = PH_FRAC;
        end
      end
      PH_FRAC: begin
        if (dig) begin
          do_digit = 1'b1;
        end else if (is_e) begin
          st_o.phase = PH_E;
        end else begin
          do_emit = 1'b1;
        end
      end
      PH_E, PH_ESIGN: begin
        if (st_i.phase == PH_E && is_minus) begin
          st_o.exp_neg = 1'b1;
          st_o.phase   = PH_ESIGN;
        end else if (st_i.phase == PH_E && is_plus) begin
          st_o.phase = PH_ESIGN;
        end else if (!dig) begin
          do_emit = 1'b1;
          err     = 1'b1;
        end else begin
          st_o.exp_digits = {12'd0, d};
          st_o.phase      = PH_EXP;
        end
      end
      PH_EXP: begin
        if (dig) begin
          st_o.exp_digits = edv_add;
        end else begin
          do_emit = 1'b1;
        end
      end
      default: st_o = clr;
    endcase
    if (do_digit) begin
      st_o.mantissa = mant_add;
      st_o.exponent = exp_add;
      st_o.inexact  = inexact_add;
    end
    if (do_emit) begin
      st_o = clr;
    end
  end

  // Result fields; an error clears the number fields
  assign emit_o            = do_emit;
  assign res_o.status      = err;
  assign res_o.negative    = err ? 1'b0 : st_i.negative;
  assign res_o.mantissa    = err ? '0 : st_i.mantissa;
  assign res_o.exponent    = err ? '0 : sat16(exp_sum);
  assign res_o.inexact     = err ? 1'b0 : st_i.inexact;
  assign res_o.stop_char   = eoi_i ? 8'd0 : ch_i;
  assign res_o.stop_is_end = eoi_i;

endmodule
